FILE: design/touch_report_event_decoder_top_assert.svh
// Assertion macros used by the back end of the touch report event decoder.
`ifndef TOUCH_REPORT_EVENT_DECODER_TOP_ASSERT_SVH
`define TOUCH_REPORT_EVENT_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/trd_pkg.sv
// Package with types, codes and helpers of the touch report event decoder.
package trd_pkg;

  localparam int FINGER_COUNT_DEF = 2;
  localparam int SLOTS_PER_FINGER = 7;
  localparam int TAIL_SLOTS       = 3;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Event types.
  localparam logic [1:0] EVT_SYN = 2'd0;
  localparam logic [1:0] EVT_KEY = 2'd1;
  localparam logic [1:0] EVT_ABS = 2'd3;

  // Event codes.
  localparam logic [9:0] CODE_SYN_REPORT   = 10'h000;
  localparam logic [9:0] CODE_SYN_MT       = 10'h002;
  localparam logic [9:0] CODE_KEY_MENU     = 10'h08b;
  localparam logic [9:0] CODE_KEY_HOME     = 10'h0ac;
  localparam logic [9:0] CODE_KEY_BACK     = 10'h09e;
  localparam logic [9:0] CODE_BTN_TOUCH    = 10'h14a;
  localparam logic [9:0] CODE_ABS_MAJOR    = 10'h030;
  localparam logic [9:0] CODE_ABS_X        = 10'h035;
  localparam logic [9:0] CODE_ABS_Y        = 10'h036;
  localparam logic [9:0] CODE_ABS_ID       = 10'h039;
  localparam logic [9:0] CODE_ABS_PRESSURE = 10'h03a;

  localparam logic [15:0] KEY_ROW_Y    = 16'd1500;
  localparam logic [15:0] KEY_MENU_X   = 16'd40;
  localparam logic [15:0] KEY_HOME_X   = 16'd80;
  localparam logic [15:0] KEY_BACK_X   = 16'd120;
  localparam logic [15:0] PRESSURE_VAL = 16'd15;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SWAP_XY       = 3'd0,
    CFG_MIRROR_X      = 3'd1,
    CFG_MIRROR_Y      = 3'd2,
    CFG_SCREEN_WIDTH  = 3'd3,
    CFG_SCREEN_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        swap_xy;
    logic        mirror_x;
    logic        mirror_y;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [9:0] code;
  } key_t;

  // One decoded finger as the back end needs it.
  typedef struct packed {
    logic [3:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  size;
    logic        key_row;
    logic [9:0]  key_code;
  } finger_t;

  typedef struct packed {
    logic [1:0]  etype;
    logic [9:0]  code;
    logic [15:0] value;
    logic        last;
  } evt_t;

  function automatic key_t key_lookup(input logic [15:0] x);
    key_t k;
    k.hit  = 1'b1;
    k.code = CODE_KEY_MENU;
    if (x == KEY_MENU_X) begin
      k.code = CODE_KEY_MENU;
    end else if (x == KEY_HOME_X) begin
      k.code = CODE_KEY_HOME;
    end else if (x == KEY_BACK_X) begin
      k.code = CODE_KEY_BACK;
    end else begin
      k.hit = 1'b0;
    end
    return k;
  endfunction

endpackage

FILE: design/trd_front.sv
// Front end: unpacks finger records and classifies which events a report needs.
module trd_front #(
  parameter int FINGER_COUNT = trd_pkg::FINGER_COUNT_DEF,
  parameter int NSLOT = FINGER_COUNT * trd_pkg::SLOTS_PER_FINGER + trd_pkg::TAIL_SLOTS
) (
  input  trd_pkg::cfg_t                      cfg,
  input  logic [7:0]                         status_byte,
  input  logic [47:0]                        first_finger,
  input  logic [47:0]                        second_finger,
  output trd_pkg::finger_t [FINGER_COUNT-1:0] fingers,
  output logic [9:0]                         rel_code,
  output logic [NSLOT-1:0]                   mask
);

  localparam int SPF = trd_pkg::SLOTS_PER_FINGER;

  logic [47:0]    rec;
  logic [15:0]    sx;
  logic [15:0]    sy;
  logic [15:0]    mx;
  logic [15:0]    my;
  logic           emit;
  logic           key_row;
  trd_pkg::key_t  key;
  logic           decoded;
  logic [15:0]    last_y;
  trd_pkg::key_t  last_key;
  logic           touches_zero;

  always_comb begin
    mask     = '0;
    decoded  = 1'b0;
    last_y   = '0;
    last_key = '0;
    rec      = first_finger;
    sx       = '0;
    sy       = '0;
    mx       = '0;
    my       = '0;
    emit     = 1'b0;
    key_row  = 1'b0;
    key      = '0;
    for (int f = 0; f < FINGER_COUNT; f++) begin
      rec = (f == 0) ? first_finger : second_finger;
      sx  = {4'd0, rec[43:40], rec[39:32]};
      sy  = {4'd0, rec[27:24], rec[23:16]};
      if (cfg.swap_xy) begin
        sx = {4'd0, rec[27:24], rec[23:16]};
        sy = {4'd0, rec[43:40], rec[39:32]};
      end
      mx = cfg.mirror_x ? ({4'd0, cfg.screen_width} - sx) : sx;
      my = cfg.mirror_y ? ({4'd0, cfg.screen_height} - sy) : sy;
      key_row = (my == trd_pkg::KEY_ROW_Y);
      key     = trd_pkg::key_lookup(mx);
      // Bit 6 alone marks a record that is decoded but silent.
      emit    = !rec[46];

      fingers[f].id       = rec[31:28];
      fingers[f].x        = mx;
      fingers[f].y        = my;
      fingers[f].size     = rec[7:4];
      fingers[f].key_row  = key_row;
      fingers[f].key_code = key.code;

      mask[f*SPF + 0] = emit;
      mask[f*SPF + 1] = emit && (!key_row || key.hit);
      for (int k = 2; k < SPF - 1; k++) begin
        mask[f*SPF + k] = emit && !key_row;
      end
      mask[f*SPF + SPF - 1] = emit;

      if (rec[47:46] != 2'b11) begin
        decoded  = 1'b1;
        last_y   = my;
        last_key = key;
      end
    end

    touches_zero     = (status_byte[2:0] == 3'd0);
    mask[NSLOT - 3]  = touches_zero && decoded && (last_y == trd_pkg::KEY_ROW_Y) &&
                       last_key.hit;
    mask[NSLOT - 2]  = touches_zero;
    mask[NSLOT - 1]  = 1'b1;
    rel_code         = last_key.code;
  end

endmodule

FILE: design/trd_queue.sv
// Small FIFO of classified reports between the front and back ends.
module trd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

FILE: design/trd_back.sv
// Back end: walks the event slots of one report and emits one event a cycle unless out_ready stalls it.
`include "touch_report_event_decoder_top_assert.svh"

module trd_back #(
  parameter int FINGER_COUNT = trd_pkg::FINGER_COUNT_DEF,
  parameter int NSLOT = FINGER_COUNT * trd_pkg::SLOTS_PER_FINGER + trd_pkg::TAIL_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  trd_pkg::finger_t [FINGER_COUNT-1:0] q_fingers,
  input  logic [9:0]                          q_rel_code,
  input  logic [NSLOT-1:0]                    q_mask,
  output logic                                out_valid,
  input  logic                                out_ready,
  output trd_pkg::evt_t                       out_evt
);

  localparam int SPF = trd_pkg::SLOTS_PER_FINGER;

  trd_pkg::finger_t [FINGER_COUNT-1:0] fng_r;
  logic [9:0]                          rel_code_r;
  logic [NSLOT-1:0]                    mask_r, mask_nxt;
  logic                                active_r, active_nxt;
  logic                                out_valid_r, out_valid_nxt;
  trd_pkg::evt_t                       out_evt_r, out_evt_nxt;

  trd_pkg::evt_t    slot_ev [NSLOT];
  trd_pkg::evt_t    sel_ev;
  logic [NSLOT-1:0] pick;
  logic [NSLOT-1:0] rest;
  logic             adv;
  logic             fin;
  logic             pop;

  // Event that each slot would produce for the current report.
  always_comb begin
    for (int f = 0; f < FINGER_COUNT; f++) begin
      slot_ev[f*SPF + 0] = '{trd_pkg::EVT_ABS, trd_pkg::CODE_ABS_ID,
                             {12'd0, fng_r[f].id}, 1'b0};
      if (fng_r[f].key_row) begin
        slot_ev[f*SPF + 1] = '{trd_pkg::EVT_KEY, fng_r[f].key_code, 16'd1, 1'b0};
      end else begin
        slot_ev[f*SPF + 1] = '{trd_pkg::EVT_ABS, trd_pkg::CODE_ABS_X, fng_r[f].x, 1'b0};
      end
      slot_ev[f*SPF + 2] = '{trd_pkg::EVT_ABS, trd_pkg::CODE_ABS_Y, fng_r[f].y, 1'b0};
      slot_ev[f*SPF + 3] = '{trd_pkg::EVT_ABS, trd_pkg::CODE_ABS_PRESSURE,
                             trd_pkg::PRESSURE_VAL, 1'b0};
      slot_ev[f*SPF + 4] = '{trd_pkg::EVT_ABS, trd_pkg::CODE_ABS_MAJOR,
                             {12'd0, fng_r[f].size}, 1'b0};
      slot_ev[f*SPF + 5] = '{trd_pkg::EVT_KEY, trd_pkg::CODE_BTN_TOUCH, 16'd1, 1'b0};
      slot_ev[f*SPF + 6] = '{trd_pkg::EVT_SYN, trd_pkg::CODE_SYN_MT, 16'd0, 1'b0};
    end
    slot_ev[NSLOT - 3] = '{trd_pkg::EVT_KEY, rel_code_r, 16'd0, 1'b0};
    slot_ev[NSLOT - 2] = '{trd_pkg::EVT_KEY, trd_pkg::CODE_BTN_TOUCH, 16'd0, 1'b0};
    slot_ev[NSLOT - 1] = '{trd_pkg::EVT_SYN, trd_pkg::CODE_SYN_REPORT, 16'd0, 1'b1};
  end

  // The lowest pending slot goes out next.
  assign pick = mask_r & (~mask_r + {{(NSLOT-1){1'b0}}, 1'b1});
  assign rest = mask_r & ~pick;

  always_comb begin
    sel_ev = '0;
    for (int s = 0; s < NSLOT; s++) begin
      if (pick[s]) begin
        sel_ev = sel_ev | slot_ev[s];
      end
    end
  end

  assign adv     = active_r && (!out_valid_r || out_ready);
  assign fin     = adv && (rest == '0);
  assign q_ready = !active_r || fin;
  assign pop     = q_valid && q_ready;

  always_comb begin
    active_nxt    = active_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    out_evt_nxt   = out_evt_r;
    if (adv) begin
      mask_nxt      = rest;
      out_valid_nxt = 1'b1;
      out_evt_nxt   = sel_ev;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin) begin
      active_nxt = 1'b0;
    end
    if (pop) begin
      active_nxt = 1'b1;
      mask_nxt   = q_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_evt_r <= out_evt_nxt;
    if (pop) begin
      fng_r      <= q_fingers;
      rel_code_r <= q_rel_code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = out_evt_r;

  `TRD_ASSERT_IMP(a_active_has_work, active_r, mask_r != '0, "active report has no pending slot")
  `TRD_ASSERT_IMP(a_last_is_report, out_valid_r && out_evt_r.last,
                  out_evt_r.etype == trd_pkg::EVT_SYN &&
                  out_evt_r.code == trd_pkg::CODE_SYN_REPORT,
                  "last event is not a report sync")
  `TRD_ASSERT_NXT(a_fin_marks_last, fin, out_valid_r && out_evt_r.last,
                  "final slot did not emit the closing sync")
  `TRD_ASSERT_IMP(a_pop_when_free, pop, !active_r || fin,
                  "report loaded while another is in progress")

endmodule

FILE: design/touch_report_event_decoder_top.sv
// Top level of the touch report event decoder: configuration registers and wiring.
//
// Usage: one input item is a touch controller report (status byte and two
// six-byte finger records), taken on in_valid/in_ready. The block answers with
// a run of input events on out_valid/out_ready, one event per item, ending
// with a report sync that carries out_last_event.
// A report yields between 1 and 16 events. The back end sends one event per
// cycle unless out_ready stalls it; the event sequencer in the back end sets
// that pace. The first event of a report passes the queue, the back end's
// report registers and then the output register.
// A two-entry queue sits between the decoding front end and the event
// sequencer, so new reports are accepted while earlier events still drain.
// When the receiver stalls, the current event holds in the output register
// and in_ready drops once the queue is full.
// The user must write the configuration registers with cfg_we, cfg_index,
// cfg_wdata only while the block is idle; the block does not enforce this.
// Reset empties the queue, drops out_valid and restores the configuration
// to its defaults (swap on, mirror x on, mirror y off, width 240, height 320).
module touch_report_event_decoder_top #(
  parameter int FINGER_COUNT = trd_pkg::FINGER_COUNT_DEF,
  parameter int QUEUE_DEPTH  = trd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_status_byte,
  input  logic [47:0] in_first_finger,
  input  logic [47:0] in_second_finger,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_type,
  output logic [9:0]  out_event_code,
  output logic [15:0] out_event_value,
  output logic        out_last_event,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int NSLOT = FINGER_COUNT * trd_pkg::SLOTS_PER_FINGER + trd_pkg::TAIL_SLOTS;
  localparam int FW    = FINGER_COUNT * $bits(trd_pkg::finger_t);
  localparam int QW    = FW + 10 + NSLOT;

  trd_pkg::cfg_t cfg_r, cfg_nxt;

  trd_pkg::finger_t [FINGER_COUNT-1:0] f_fingers;
  logic [9:0]                          f_rel_code;
  logic [NSLOT-1:0]                    f_mask;
  logic [QW-1:0]                       q_wdata;
  logic [QW-1:0]                       q_rdata;
  logic                                q_valid;
  logic                                q_ready;
  trd_pkg::evt_t                       evt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        trd_pkg::CFG_SWAP_XY:       cfg_nxt.swap_xy       = cfg_wdata[0];
        trd_pkg::CFG_MIRROR_X:      cfg_nxt.mirror_x      = cfg_wdata[0];
        trd_pkg::CFG_MIRROR_Y:      cfg_nxt.mirror_y      = cfg_wdata[0];
        trd_pkg::CFG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_wdata;
        trd_pkg::CFG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swap_xy       <= 1'b1;
      cfg_r.mirror_x      <= 1'b1;
      cfg_r.mirror_y      <= 1'b0;
      cfg_r.screen_width  <= 12'd240;
      cfg_r.screen_height <= 12'd320;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  trd_front #(
    .FINGER_COUNT (FINGER_COUNT),
    .NSLOT        (NSLOT)
  ) u_front (
    .cfg           (cfg_r),
    .status_byte   (in_status_byte),
    .first_finger  (in_first_finger),
    .second_finger (in_second_finger),
    .fingers       (f_fingers),
    .rel_code      (f_rel_code),
    .mask          (f_mask)
  );

  assign q_wdata = {f_mask, f_rel_code, f_fingers};

  trd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (q_wdata),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_rdata)
  );

  trd_back #(
    .FINGER_COUNT (FINGER_COUNT),
    .NSLOT        (NSLOT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_fingers  (q_rdata[FW-1:0]),
    .q_rel_code (q_rdata[FW+9:FW]),
    .q_mask     (q_rdata[QW-1:FW+10]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_evt    (evt)
  );

  assign out_event_type  = evt.etype;
  assign out_event_code  = evt.code;
  assign out_event_value = evt.value;
  assign out_last_event  = evt.last;

endmodule
